/* sv/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation matrix to quaternion
// converter.
// Holds the request payload structs, the branch codes and the stage records
// of the pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Q1.14 unit value and the saturation bound of every output component.
    localparam int QONE = 16384;

    // Square root: 17 result bits, one bit resolved per stage.
    localparam int SQ_BITS = 17;
    // Divider: quotient bits 14..0, one bit per stage after an overflow check.
    localparam int DV_BITS = 15;

    // Which quaternion component takes the scale S/4.
    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } sel_t;

    // Input request: the nine matrix entries, signed Q1.14.
    typedef struct packed {
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m13;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m23;
        logic signed [15:0] m31;
        logic signed [15:0] m32;
        logic signed [15:0] m33;
    } in_t;

    // Result request: the quaternion with the scalar part negated.
    typedef struct packed {
        logic signed [15:0] quat_scalar_neg;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } out_t;

    // Branch selection and square-root argument.
    typedef struct packed {
        sel_t              sel;
        logic [2:0]        neg;
        logic [2:0][16:0]  mag;
        logic [16:0]       arg;
    } prep_t;

    // Square-root stage record.
    typedef struct packed {
        sel_t              sel;
        logic [2:0]        neg;
        logic [2:0][16:0]  mag;
        logic [33:0]       rem;
        logic [16:0]       root;
    } sq_t;

    // Divider stage record, three lanes sharing the divisor 2*S.
    typedef struct packed {
        sel_t              sel;
        logic [2:0]        neg;
        logic [16:0]       s;
        logic [2:0]        ovf;
        logic [2:0][33:0]  rem;
        logic [2:0][14:0]  quo;
    } dv_t;

endpackage

/* sv/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion.
// Trace-branch conversion in Q1.14 with a bit-per-stage square root and three
// bit-per-stage dividers.
// ----------------------------------------------------------------------------
// The block accepts one matrix request per clock while the output is not stalled,
// and returns one quaternion request per matrix, in order, through one branch
// selection stage, 17 square-root stages, 16 divider stages and the output
// register. That depth is set by the bit-per-stage square root and the
// bit-per-stage dividers. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stalled result holds every
// stage and nothing is lost or repeated. Components saturate to plus or minus
// one, and the scalar part comes out negated.
module rotation_matrix_to_quaternion (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rmq_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rmq_pkg::out_t m_data
);

    localparam int SQ = rmq_pkg::SQ_BITS;
    localparam int DV = rmq_pkg::DV_BITS;

    logic              adv;
    logic              pr_vld_reg;
    logic [SQ-1:0]     sq_vld_reg;
    logic [DV:0]       dv_vld_reg;
    logic              out_vld_reg;

    rmq_pkg::prep_t    pr_reg, pr_next;
    rmq_pkg::sq_t      sq_reg  [SQ];
    rmq_pkg::sq_t      sq_next [SQ];
    rmq_pkg::dv_t      dv_reg  [DV+1];
    rmq_pkg::dv_t      dv_next [DV+1];
    rmq_pkg::out_t     out_reg, out_next;

    // Global advance: move when the output slot is free or being emptied.
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Branch selection, square-root argument and the three numerators.
    always_comb begin
        logic signed [17:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
        logic signed [17:0] tr, comb_v;
        logic signed [18:0] arg_s;
        logic signed [17:0] n0, n1, n2, na, nb, nc, nd, ne, nf;
        e11 = 18'(s_data.m11);
        e12 = 18'(s_data.m12);
        e13 = 18'(s_data.m13);
        e21 = 18'(s_data.m21);
        e22 = 18'(s_data.m22);
        e23 = 18'(s_data.m23);
        e31 = 18'(s_data.m31);
        e32 = 18'(s_data.m32);
        e33 = 18'(s_data.m33);
        tr = e11 + e22 + e33;
        na = e32 - e23;
        nb = e13 - e31;
        nc = e21 - e12;
        nd = e12 + e21;
        ne = e13 + e31;
        nf = e23 + e32;
        if (tr > 18'sd0) begin
            pr_next.sel = rmq_pkg::SEL_W;
            comb_v = tr;
            n0 = na; n1 = nb; n2 = nc;
        end else if (s_data.m11 > s_data.m22 && s_data.m11 > s_data.m33) begin
            pr_next.sel = rmq_pkg::SEL_X;
            comb_v = e11 - e22 - e33;
            n0 = na; n1 = nd; n2 = ne;
        end else if (s_data.m22 > s_data.m33) begin
            pr_next.sel = rmq_pkg::SEL_Y;
            comb_v = e22 - e11 - e33;
            n0 = nb; n1 = nd; n2 = nf;
        end else begin
            pr_next.sel = rmq_pkg::SEL_Z;
            comb_v = e33 - e11 - e22;
            n0 = nc; n1 = ne; n2 = nf;
        end
        arg_s = 19'(rmq_pkg::QONE) + 19'(comb_v);
        pr_next.arg = arg_s[18] ? 17'd0 : arg_s[16:0];
        pr_next.neg = {n2[17], n1[17], n0[17]};
        pr_next.mag[0] = n0[17] ? 17'(-n0) : n0[16:0];
        pr_next.mag[1] = n1[17] ? 17'(-n1) : n1[16:0];
        pr_next.mag[2] = n2[17] ? 17'(-n2) : n2[16:0];
    end

    // Square root of arg * 2^16, one root bit per stage, most significant first.
    always_comb begin
        rmq_pkg::sq_t src;
        logic [34:0]  t;
        int           b;
        for (int k = 0; k < SQ; k++) begin
            if (k == 0) begin
                src.sel  = pr_reg.sel;
                src.neg  = pr_reg.neg;
                src.mag  = pr_reg.mag;
                src.rem  = {1'b0, pr_reg.arg, 16'b0};
                src.root = '0;
            end else begin
                src = sq_reg[k-1];
            end
            b = SQ - 1 - k;
            t = ({18'b0, src.root} << (b + 1)) + (35'd1 << (2 * b));
            sq_next[k] = src;
            if ({1'b0, src.rem} >= t) begin
                sq_next[k].rem  = src.rem - t[33:0];
                sq_next[k].root = src.root | (17'd1 << b);
            end
        end
    end

    // Dividers: rounded |num| * 2^14 / S as (num * 2^15 + S) / (2 * S).
    always_comb begin
        rmq_pkg::dv_t src;
        logic [17:0]  ds;
        logic [33:0]  t;
        logic [33:0]  dd;
        int           b;
        // Overflow stage: quotient of 2^15 or more saturates anyway.
        dv_next[0].sel = sq_reg[SQ-1].sel;
        dv_next[0].neg = sq_reg[SQ-1].neg;
        dv_next[0].s   = sq_reg[SQ-1].root;
        dv_next[0].quo = '0;
        ds = {sq_reg[SQ-1].root, 1'b0};
        for (int j = 0; j < 3; j++) begin
            dd = {2'b0, sq_reg[SQ-1].mag[j], 15'b0} + {17'b0, sq_reg[SQ-1].root};
            dv_next[0].rem[j] = dd;
            dv_next[0].ovf[j] = (dd >= {1'b0, ds, 15'b0});
        end
        // Restoring steps, quotient bit 14 down to 0.
        for (int k = 1; k <= DV; k++) begin
            src = dv_reg[k-1];
            b   = DV - k;
            t   = {16'b0, src.s, 1'b0} << b;
            dv_next[k] = src;
            for (int j = 0; j < 3; j++) begin
                if (src.rem[j] >= t) begin
                    dv_next[k].rem[j] = src.rem[j] - t;
                    dv_next[k].quo[j] = src.quo[j] | (15'd1 << b);
                end
            end
        end
    end

    // Output assembly: saturation, signs, branch placement, scalar negation.
    always_comb begin
        rmq_pkg::dv_t       src;
        logic [17:0]        cs;
        logic [15:0]        cu;
        logic signed [15:0] c;
        logic [15:0]        r;
        logic signed [15:0] d [3];
        logic signed [15:0] w, x, y, z;
        src = dv_reg[DV];
        cs  = {1'b0, src.s} + 18'd2;
        cu  = cs[17:2];
        c   = (cu > 16'(rmq_pkg::QONE)) ? 16'(rmq_pkg::QONE) : cu;
        for (int j = 0; j < 3; j++) begin
            r = (src.ovf[j] || {1'b0, src.quo[j]} > 16'(rmq_pkg::QONE))
                ? 16'(rmq_pkg::QONE) : {1'b0, src.quo[j]};
            d[j] = src.neg[j] ? -r : r;
        end
        case (src.sel)
            rmq_pkg::SEL_W: begin w = c;    x = d[0]; y = d[1]; z = d[2]; end
            rmq_pkg::SEL_X: begin w = d[0]; x = c;    y = d[1]; z = d[2]; end
            rmq_pkg::SEL_Y: begin w = d[0]; x = d[1]; y = c;    z = d[2]; end
            rmq_pkg::SEL_Z: begin w = d[0]; x = d[1]; y = d[2]; z = c;    end
            default:        begin w = '0;   x = '0;   y = '0;   z = '0;   end
        endcase
        if (src.s == 17'd0) begin
            out_next = '0;
        end else begin
            out_next.quat_scalar_neg = -w;
            out_next.quat_x          = x;
            out_next.quat_y          = y;
            out_next.quat_z          = z;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg  <= 1'b0;
            sq_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            pr_vld_reg  <= s_valid;
            sq_vld_reg  <= {sq_vld_reg[SQ-2:0], pr_vld_reg};
            dv_vld_reg  <= {dv_vld_reg[DV-1:0], sq_vld_reg[SQ-1]};
            out_vld_reg <= dv_vld_reg[DV];
        end
    end

    // Payload stages, no reset.
    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_reg <= pr_next;
            for (int k = 0; k < SQ; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k <= DV; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted request always lands in the first stage.
    a_accept_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> pr_vld_reg)
        else $error("accepted request not captured");

    // Every delivered component stays inside the Q1.14 unit range.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quat_scalar_neg >= -16'sd16384
                     && m_data.quat_scalar_neg <= 16'sd16384
                     && m_data.quat_x >= -16'sd16384 && m_data.quat_x <= 16'sd16384
                     && m_data.quat_y >= -16'sd16384 && m_data.quat_y <= 16'sd16384
                     && m_data.quat_z >= -16'sd16384 && m_data.quat_z <= 16'sd16384))
        else $error("output component out of range");

    // A finished lane-0 division without overflow leaves a remainder below the divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[DV] && dv_reg[DV].s != 17'd0 && !dv_reg[DV].ovf[0]
        |-> dv_reg[DV].rem[0] < {16'b0, dv_reg[DV].s, 1'b0})
        else $error("divider remainder not reduced");
`endif

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for rotation_matrix_to_quaternion.
// Drives matrix requests through a valid/ready driver, predicts each
// quaternion in fixed point and compares every returned request in order.
// ----------------------------------------------------------------------------
module tb;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    rmq_pkg::in_t   s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    rmq_pkg::out_t  m_data;

    rmq_pkg::in_t   pending_mats[$];
    rmq_pkg::out_t  expected_quats[$];
    int    errors = 0;
    int    src_idle_pct = 0;
    int    dst_stall_pct = 0;
    bit    stim_done = 1'b0;

    rotation_matrix_to_quaternion dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Append one matrix to the stimulus queue.
    task automatic queue_mat(input rmq_pkg::in_t m);
        pending_mats.insert(pending_mats.size(), m);
    endtask

    // Saturate to the Q1.14 range of plus or minus one.
    function automatic longint clamp_q14(input longint v);
        if (v > rmq_pkg::QONE) return rmq_pkg::QONE;
        if (v < -rmq_pkg::QONE) return -rmq_pkg::QONE;
        return v;
    endfunction

    // Integer square root by the bit-pair method.
    function automatic longint floor_sqrt(input longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Signed num/S in Q14, magnitude rounded half away from zero.
    function automatic longint scaled_quotient(input longint num, input longint s);
        longint mag;
        longint q;
        mag = (num < 0 ? -num : num) * rmq_pkg::QONE;
        q = (mag * 2 + s) / (2 * s);
        if (q > 1000000) q = 1000000;
        return clamp_q14(num < 0 ? -q : q);
    endfunction

    // Predict the quaternion for one matrix.
    function automatic rmq_pkg::out_t predict_quat(input rmq_pkg::in_t m);
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint tr, arg, s, c, qw, qx, qy, qz;
        rmq_pkg::sel_t sel;
        rmq_pkg::out_t q;
        a11 = m.m11; a12 = m.m12; a13 = m.m13;
        a21 = m.m21; a22 = m.m22; a23 = m.m23;
        a31 = m.m31; a32 = m.m32; a33 = m.m33;
        tr = a11 + a22 + a33;
        if (tr > 0) begin
            arg = rmq_pkg::QONE + tr; sel = rmq_pkg::SEL_W;
        end else if (a11 > a22 && a11 > a33) begin
            arg = rmq_pkg::QONE + a11 - a22 - a33; sel = rmq_pkg::SEL_X;
        end else if (a22 > a33) begin
            arg = rmq_pkg::QONE + a22 - a11 - a33; sel = rmq_pkg::SEL_Y;
        end else begin
            arg = rmq_pkg::QONE + a33 - a11 - a22; sel = rmq_pkg::SEL_Z;
        end
        if (arg < 0) arg = 0;
        s = floor_sqrt(arg * 65536);
        if (s == 0) return '0;
        c = clamp_q14((s + 2) >>> 2);
        case (sel)
            rmq_pkg::SEL_W: begin
                qw = c;
                qx = scaled_quotient(a32 - a23, s);
                qy = scaled_quotient(a13 - a31, s);
                qz = scaled_quotient(a21 - a12, s);
            end
            rmq_pkg::SEL_X: begin
                qw = scaled_quotient(a32 - a23, s);
                qx = c;
                qy = scaled_quotient(a12 + a21, s);
                qz = scaled_quotient(a13 + a31, s);
            end
            rmq_pkg::SEL_Y: begin
                qw = scaled_quotient(a13 - a31, s);
                qx = scaled_quotient(a12 + a21, s);
                qy = c;
                qz = scaled_quotient(a23 + a32, s);
            end
            default: begin
                qw = scaled_quotient(a21 - a12, s);
                qx = scaled_quotient(a13 + a31, s);
                qy = scaled_quotient(a23 + a32, s);
                qz = c;
            end
        endcase
        q.quat_scalar_neg = 16'(-qw);
        q.quat_x = 16'(qx);
        q.quat_y = 16'(qy);
        q.quat_z = 16'(qz);
        return q;
    endfunction

    function automatic logic signed [15:0] any_entry();
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] q14_entry();
        return 16'($urandom_range(32768) - 16384);
    endfunction

    // Rotation about one axis with random cos/sin, sometimes with small noise on m12.
    function automatic rmq_pkg::in_t rotation_mat();
        int ax;
        int c;
        int sn;
        rmq_pkg::in_t m;
        ax = $urandom_range(2);
        c = $urandom_range(32768) - 16384;
        sn = $urandom_range(1) ? int'($sqrt(real'(268435456 - c * c)))
                               : -int'($sqrt(real'(268435456 - c * c)));
        m = '0;
        case (ax)
            0: begin
                m.m11 = 16'sd16384; m.m22 = 16'(c); m.m33 = 16'(c);
                m.m23 = 16'(-sn); m.m32 = 16'(sn);
            end
            1: begin
                m.m22 = 16'sd16384; m.m11 = 16'(c); m.m33 = 16'(c);
                m.m13 = 16'(sn); m.m31 = 16'(-sn);
            end
            default: begin
                m.m33 = 16'sd16384; m.m11 = 16'(c); m.m22 = 16'(c);
                m.m12 = 16'(-sn); m.m21 = 16'(sn);
            end
        endcase
        if ($urandom_range(3) == 0) m.m12 = m.m12 + 16'($urandom_range(64) - 32);
        return m;
    endfunction

    // Driver: present queued matrices, hold until accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_mats.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_data <= pending_mats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Predict on acceptance; check each returned request in order.
    always @(posedge aclk) begin
        rmq_pkg::out_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_quats.insert(expected_quats.size(), predict_quat(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_quats.size() == 0) begin
                    $error("unexpected quaternion %h", m_data);
                    errors++;
                end else begin
                    e = expected_quats.pop_front();
                    if (m_data.quat_scalar_neg !== e.quat_scalar_neg) begin
                        $error("quat_scalar_neg exp %0d got %0d",
                               e.quat_scalar_neg, m_data.quat_scalar_neg);
                        errors++;
                    end
                    if (m_data.quat_x !== e.quat_x) begin
                        $error("quat_x exp %0d got %0d", e.quat_x, m_data.quat_x);
                        errors++;
                    end
                    if (m_data.quat_y !== e.quat_y) begin
                        $error("quat_y exp %0d got %0d", e.quat_y, m_data.quat_y);
                        errors++;
                    end
                    if (m_data.quat_z !== e.quat_z) begin
                        $error("quat_z exp %0d got %0d", e.quat_z, m_data.quat_z);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus: directed corners, then random phases of idling and stalls.
    initial begin
        rmq_pkg::in_t m;
        int k;
        int ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // Identity, and half-turns selecting each diagonal branch.
        m = '0; m.m11 = 16'sd16384; m.m22 = 16'sd16384; m.m33 = 16'sd16384;
        queue_mat(m);
        m = '0; m.m11 = 16'sd16384; m.m22 = -16'sd16384; m.m33 = -16'sd16384;
        queue_mat(m);
        m = '0; m.m11 = -16'sd16384; m.m22 = 16'sd16384; m.m33 = -16'sd16384;
        queue_mat(m);
        m = '0; m.m11 = -16'sd16384; m.m22 = -16'sd16384; m.m33 = 16'sd16384;
        queue_mat(m);
        // Zero matrix: trace not positive, ties fall to the last branch.
        m = '0; queue_mat(m);
        // Strongly negative trace that falls to the second diagonal branch.
        m = '0; m.m11 = -16'sd16384; m.m22 = -16'sd16384; m.m33 = 16'sh8000;
        queue_mat(m);
        // Entries mostly at the field extremes.
        queue_mat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                    16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        queue_mat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        queue_mat('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001,
                    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001});
        // Tiny positive trace with large off-diagonals: saturating quotients.
        queue_mat('{16'sh0001, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh0000,
                    16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000});
        for (k = 0; k < 10; k++) queue_mat(rotation_mat());
        while (pending_mats.size() != 0) @(posedge aclk);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin src_idle_pct = 48; dst_stall_pct = 0; end
                2: begin src_idle_pct = 0; dst_stall_pct = 48; end
                3: begin src_idle_pct = 8; dst_stall_pct = 8; end
                default: begin src_idle_pct = 0; dst_stall_pct = 0; end
            endcase
            for (k = 0; k < 320; k++) begin
                case ($urandom_range(9))
                    0: queue_mat('{any_entry(), any_entry(), any_entry(),
                        any_entry(), any_entry(), any_entry(), any_entry(), any_entry(),
                        any_entry()});
                    1, 2: queue_mat('{q14_entry(), q14_entry(), q14_entry(),
                        q14_entry(), q14_entry(), q14_entry(), q14_entry(), q14_entry(),
                        q14_entry()});
                    default: queue_mat(rotation_mat());
                endcase
            end
            while (pending_mats.size() != 0) @(posedge aclk);
        end
        while (s_valid) @(posedge aclk);
        while (expected_quats.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
sv/rmq_pkg.sv
sv/rotation_matrix_to_quaternion.sv
bench/tb.sv
